/* src/ppm_pkg.sv */
// Shared widths, types, register indexes and the reciprocal table for the mask-to-RGB888 block.
`default_nettype none

package ppm_pkg;

    // Pixel word width used when no other value is given.
    localparam int PIXEL_BITS_DEF = 32;

    // Fixed datapath widths.
    localparam int CHAN_BITS   = 32;
    localparam int BYTE_BITS   = 8;
    localparam int SH_BITS     = $clog2(CHAN_BITS);
    localparam int W_BITS      = $clog2(CHAN_BITS + 1);
    localparam int SCALED_BITS = CHAN_BITS + BYTE_BITS;
    localparam int HALF_BITS   = SCALED_BITS / 2;
    localparam int RECIP_BITS  = SCALED_BITS + 1;
    localparam int RECIP_LO_BITS = HALF_BITS;
    localparam int RECIP_HI_BITS = RECIP_BITS - HALF_BITS;
    localparam int XHI_BITS    = SCALED_BITS - HALF_BITS;
    localparam int PP_HH_BITS  = XHI_BITS + RECIP_HI_BITS;
    localparam int PP_HL_BITS  = XHI_BITS + RECIP_LO_BITS;
    localparam int PP_LH_BITS  = HALF_BITS + RECIP_HI_BITS;
    localparam int PP_LL_BITS  = HALF_BITS + RECIP_LO_BITS;
    localparam int SUM_BITS    = SCALED_BITS + RECIP_BITS;
    localparam int HI_BITS     = SUM_BITS - SCALED_BITS;

    // Register stages from the input register to the output register.
    localparam int STAGES = 6;

    typedef logic [CHAN_BITS-1:0]  word_t;
    typedef logic [BYTE_BITS-1:0]  byte_t;
    typedef logic [RECIP_BITS-1:0] recip_t;
    typedef recip_t recip_tab_t [0:CHAN_BITS];

    // Configuration register indexes.
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t IDX_RED   = 2'd0;
    localparam cfg_idx_t IDX_GREEN = 2'd1;
    localparam cfg_idx_t IDX_BLUE  = 2'd2;

    localparam word_t RED_MASK_RST   = 32'h00FF_0000;
    localparam word_t GREEN_MASK_RST = 32'h0000_FF00;
    localparam word_t BLUE_MASK_RST  = 32'h0000_00FF;

    // Per-stage load strobes handed from the pipeline control to each channel.
    typedef struct packed {
        logic mask_and;
        logic scale;
        logic mul;
        logic sum;
        logic result;
    } ppm_load_t;

    // Entry w holds c with 2^N + c = ceil(2^(N+w) / (2^w - 1)), N = SCALED_BITS.
    // The quotient 2^N / (2^w - 1) is a geometric series of powers of two whose
    // fractional tail lies above zero and at most one, so c is the series plus one.
    function automatic recip_tab_t build_recip();
        recip_tab_t tab;
        for (int w = 0; w <= CHAN_BITS; w++)
        begin
            tab[w] = '0;
            if (w > 0)
            begin
                tab[w] = RECIP_BITS'(1);
                for (int k = 1; k <= SCALED_BITS; k++)
                begin
                    if (w * k <= SCALED_BITS)
                    begin
                        tab[w] = tab[w] + (RECIP_BITS'(1) << (SCALED_BITS - w * k));
                    end
                end
            end
        end
        return tab;
    endfunction

    localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

`default_nettype wire

/* src/ppm_pix_if.sv */
// Handshake channel carrying one packed pixel word per request.
`default_nettype none

interface ppm_pix_if;
    import ppm_pkg::*;

    logic  valid;
    logic  ready;
    word_t packed_pixel;

    modport source (output valid, output packed_pixel, input ready);
    modport sink   (input valid, input packed_pixel, output ready);
endinterface

`default_nettype wire

/* src/ppm_rgb_if.sv */
// Handshake channel carrying one blue, green and red byte triple per request.
`default_nettype none

interface ppm_rgb_if;
    import ppm_pkg::*;

    logic  valid;
    logic  ready;
    byte_t blue_out;
    byte_t green_out;
    byte_t red_out;

    modport source (output valid, output blue_out, output green_out, output red_out,
                    input ready);
    modport sink   (input valid, input blue_out, input green_out, input red_out,
                    output ready);
endinterface

`default_nettype wire

/* src/packed_pixel_mask_to_rgb888.sv */
// Top level of the packed pixel to RGB888 converter with configurable channel masks.
//
// Usage: a packed pixel word arrives on the pixel channel; one request carries one
// word. Three masks, written through the configuration port (index 0 red, 1 green,
// 2 blue), select the fields. Each field is shifted down to the mask's lowest set
// bit and scaled to eight bits as floor(field * 255 / (2^bits - 1)), where bits is
// the number of set bits in the mask. The rgb channel returns the blue, green and
// red bytes as one request per pixel.
// Throughput is one pixel per clock while the receiver keeps taking results. A
// pixel passes through six register stages: an input register, then the mask, the
// shift and scale, four partial products of the reciprocal multiply, their sum, and
// the output register, which is the final byte selection.
// Reset empties the pipeline and loads the masks 0x00FF0000, 0x0000FF00 and
// 0x000000FF. When the receiver holds off, each stage keeps its data and the ready
// signal walks back only through full stages, so empty slots keep taking requests.
// A mask change applies to every pixel accepted on or after the writing edge.
`default_nettype none

module packed_pixel_mask_to_rgb888 #(
    parameter int PIXEL_BITS = ppm_pkg::PIXEL_BITS_DEF
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  ppm_pkg::cfg_idx_t  cfg_idx,
    input  ppm_pkg::word_t     cfg_data,
    ppm_pix_if.sink            pixel,
    ppm_rgb_if.source          rgb
);
    import ppm_pkg::*;

    // Bits of the pixel and of the masks that take part at all.
    localparam int EFF_BITS = (PIXEL_BITS < CHAN_BITS) ? PIXEL_BITS : CHAN_BITS;

    logic [EFF_BITS-1:0] red_mask_reg, red_mask_next;
    logic [EFF_BITS-1:0] green_mask_reg, green_mask_next;
    logic [EFF_BITS-1:0] blue_mask_reg, blue_mask_next;

    logic [EFF_BITS-1:0] pix_reg, pix_next;

    // Valid bit of each stage, and whether that stage can take new data.
    logic [STAGES-1:0] vld_reg, vld_next;
    logic [STAGES-1:0] stage_rdy;

    ppm_load_t load;
    byte_t     red_byte, green_byte, blue_byte;

    // Mask registers: a write to an index beyond the list is dropped.
    always_comb
    begin
        red_mask_next   = red_mask_reg;
        green_mask_next = green_mask_reg;
        blue_mask_next  = blue_mask_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                IDX_RED:   red_mask_next   = cfg_data[EFF_BITS-1:0];
                IDX_GREEN: green_mask_next = cfg_data[EFF_BITS-1:0];
                IDX_BLUE:  blue_mask_next  = cfg_data[EFF_BITS-1:0];
                default:   red_mask_next   = red_mask_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_mask_reg   <= EFF_BITS'(RED_MASK_RST);
            green_mask_reg <= EFF_BITS'(GREEN_MASK_RST);
            blue_mask_reg  <= EFF_BITS'(BLUE_MASK_RST);
        end
        else
        begin
            red_mask_reg   <= red_mask_next;
            green_mask_reg <= green_mask_next;
            blue_mask_reg  <= blue_mask_next;
        end
    end

    // Pipeline control. A stage can load when it is empty or when the stage after
    // it is moving; the last stage moves when the receiver takes the result.
    always_comb
    begin
        stage_rdy[STAGES-1] = !vld_reg[STAGES-1] || rgb.ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            stage_rdy[k] = !vld_reg[k] || stage_rdy[k+1];
        end

        vld_next[0] = stage_rdy[0] ? pixel.valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            vld_next[k] = stage_rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Data registers load only when a valid request moves into them.
    always_comb
    begin
        load.mask_and = stage_rdy[1] && vld_reg[0];
        load.scale    = stage_rdy[2] && vld_reg[1];
        load.mul      = stage_rdy[3] && vld_reg[2];
        load.sum      = stage_rdy[4] && vld_reg[3];
        load.result   = stage_rdy[5] && vld_reg[4];
        pix_next      = pixel.packed_pixel[EFF_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0] && pixel.valid)
        begin
            pix_reg <= pix_next;
        end
    end

    ppm_chan u_red (
        .clk       (clk),
        .mask      (CHAN_BITS'(red_mask_reg)),
        .pix       (CHAN_BITS'(pix_reg)),
        .load      (load),
        .chan_byte (red_byte)
    );

    ppm_chan u_green (
        .clk       (clk),
        .mask      (CHAN_BITS'(green_mask_reg)),
        .pix       (CHAN_BITS'(pix_reg)),
        .load      (load),
        .chan_byte (green_byte)
    );

    ppm_chan u_blue (
        .clk       (clk),
        .mask      (CHAN_BITS'(blue_mask_reg)),
        .pix       (CHAN_BITS'(pix_reg)),
        .load      (load),
        .chan_byte (blue_byte)
    );

    assign pixel.ready   = stage_rdy[0];
    assign rgb.valid     = vld_reg[STAGES-1];
    assign rgb.blue_out  = blue_byte;
    assign rgb.green_out = green_byte;
    assign rgb.red_out   = red_byte;

endmodule

`default_nettype wire

/* src/ppm_chan.sv */
// One colour channel: field extraction and scaling to eight bits over five register stages.
`default_nettype none

module ppm_chan (
    input  wire                  clk,
    input  ppm_pkg::word_t       mask,
    input  ppm_pkg::word_t       pix,
    input  ppm_pkg::ppm_load_t   load,
    output ppm_pkg::byte_t       chan_byte
);
    import ppm_pkg::*;

    // Values derived from the mask; sh and w are registered from the mask register
    // and c from w, which keeps them ahead of any request that uses them.
    logic [SH_BITS-1:0] sh_reg, sh_next;
    logic [W_BITS-1:0]  w_reg, w_next;
    recip_t             c_reg, c_next;

    word_t                    and_reg, and_next;
    word_t                    field;
    logic [SCALED_BITS-1:0]   scaled_reg, scaled_next;
    logic [SCALED_BITS-1:0]   xm_reg;
    logic [PP_HH_BITS-1:0]    pp_hh_reg, pp_hh_next;
    logic [PP_HL_BITS-1:0]    pp_hl_reg, pp_hl_next;
    logic [PP_LH_BITS-1:0]    pp_lh_reg, pp_lh_next;
    logic [PP_LL_BITS-1:0]    pp_ll_reg, pp_ll_next;
    logic [SUM_BITS-1:0]      sum_full;
    logic [HI_BITS-1:0]       hi_reg, hi_next;
    logic [HI_BITS-1:0]       quot;
    byte_t                    byte_reg, byte_next;

    always_comb
    begin
        sh_next = '0;
        w_next  = '0;
        for (int i = CHAN_BITS - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                sh_next = SH_BITS'(i);
            end
        end
        for (int i = 0; i < CHAN_BITS; i++)
        begin
            w_next = w_next + W_BITS'(mask[i]);
        end
        c_next = RECIP_TAB[w_reg];
    end

    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
        w_reg  <= w_next;
        c_reg  <= c_next;
    end

    always_comb
    begin
        and_next = pix & mask;

        // Field times 255, written as a shift and a subtract.
        field       = and_reg >> sh_reg;
        scaled_next = (SCALED_BITS'(field) << BYTE_BITS) - SCALED_BITS'(field);

        // The scaled value times c, as four partial products.
        pp_hh_next = PP_HH_BITS'(scaled_reg[SCALED_BITS-1:HALF_BITS])
                   * PP_HH_BITS'(c_reg[RECIP_BITS-1:HALF_BITS]);
        pp_hl_next = PP_HL_BITS'(scaled_reg[SCALED_BITS-1:HALF_BITS])
                   * PP_HL_BITS'(c_reg[HALF_BITS-1:0]);
        pp_lh_next = PP_LH_BITS'(scaled_reg[HALF_BITS-1:0])
                   * PP_LH_BITS'(c_reg[RECIP_BITS-1:HALF_BITS]);
        pp_ll_next = PP_LL_BITS'(scaled_reg[HALF_BITS-1:0])
                   * PP_LL_BITS'(c_reg[HALF_BITS-1:0]);

        // The full product with 2^N + c; the quotient sits above bit N + w.
        sum_full = (SUM_BITS'(xm_reg) << SCALED_BITS)
                 + (SUM_BITS'(pp_hh_reg) << (2 * HALF_BITS))
                 + (SUM_BITS'(pp_hl_reg) << HALF_BITS)
                 + (SUM_BITS'(pp_lh_reg) << HALF_BITS)
                 + SUM_BITS'(pp_ll_reg);
        hi_next  = sum_full[SUM_BITS-1:SCALED_BITS];

        quot      = hi_reg >> w_reg;
        byte_next = quot[BYTE_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load.mask_and)
        begin
            and_reg <= and_next;
        end
        if (load.scale)
        begin
            scaled_reg <= scaled_next;
        end
        if (load.mul)
        begin
            xm_reg    <= scaled_reg;
            pp_hh_reg <= pp_hh_next;
            pp_hl_reg <= pp_hl_next;
            pp_lh_reg <= pp_lh_next;
            pp_ll_reg <= pp_ll_next;
        end
        if (load.sum)
        begin
            hi_reg <= hi_next;
        end
        if (load.result)
        begin
            byte_reg <= byte_next;
        end
    end

    assign chan_byte = byte_reg;

endmodule

`default_nettype wire

/* verif/packed_pixel_mask_to_rgb888_tb.sv */
// Self-checking testbench for the packed pixel mask to RGB888 converter.
`timescale 1ns / 100ps

module packed_pixel_mask_to_rgb888_tb;
    import ppm_pkg::*;

    // Index 3 fits the index port but names no register, so a write to it must be dropped.
    localparam cfg_idx_t IDX_UNUSED = 2'd3;

    // Room for the pipeline to empty out after the last expected request has arrived.
    localparam int DRAIN_CYCLES = STAGES + 4;

    // Number of mismatches reported in full; later ones are only counted.
    localparam int REPORT_LIMIT = 10;

    // Random part of the run: mask settings and pixels per setting.
    localparam int RANDOM_SETTINGS = 8;
    localparam int PIXELS_PER_SETTING = 60;

    typedef struct packed {
        byte_t blue;
        byte_t green;
        byte_t red;
    } rgb_bytes_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_idx_t cfg_idx;
    word_t cfg_data;

    ppm_pix_if pix_ch ();
    ppm_rgb_if rgb_ch ();

    packed_pixel_mask_to_rgb888 dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .pixel    (pix_ch),
        .rgb      (rgb_ch)
    );

    // Our own copy of the three channel masks, kept in step with every register write.
    word_t red_sel;
    word_t green_sel;
    word_t blue_sel;

    // Byte triples still owed by the block, oldest first.
    rgb_bytes_t expected_rgb[$];

    // While set, neither the pixel sender nor the result receiver holds off.
    bit steady;

    int fail_count;
    int pixels_sent;
    int results_checked;
    int settings_count;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Scales one channel to eight bits. The shift is the position of the lowest set
    // mask bit and the bit count is the number of set bits. A scattered mask can give a
    // field above 2^bits - 1, so the quotient may exceed 255 and only its low byte is kept.
    function automatic byte_t scale_channel(word_t px, word_t sel);
        int unsigned sh;
        int unsigned nbits;
        logic [63:0] field;
        logic [63:0] top;
        if (sel == '0)
        begin
            return '0;
        end
        sh = 0;
        while (!sel[sh])
        begin
            sh++;
        end
        nbits = $countones(sel);
        field = 64'(px & sel) >> sh;
        top = (64'd1 << nbits) - 64'd1;
        return byte_t'((field * 64'd255) / top);
    endfunction

    function automatic rgb_bytes_t convert_pixel(word_t px);
        rgb_bytes_t bytes;
        bytes.blue  = scale_channel(px, blue_sel);
        bytes.green = scale_channel(px, green_sel);
        bytes.red   = scale_channel(px, red_sel);
        return bytes;
    endfunction

    // ------------------------------------------------------------------
    // Failure reporting
    // ------------------------------------------------------------------

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the checker
    // ------------------------------------------------------------------

    // The receiver holds off at random, about a fifth of the time, except during a steady stretch.
    always @(posedge clk)
    begin
        rgb_ch.ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 20);
    end

    // Each accepted request on the rgb channel is matched against the oldest expected
    // triple. Values are sampled at the edge itself, so they are the ones the block saw.
    always @(posedge clk)
    begin : check_results
        rgb_bytes_t got;
        rgb_bytes_t want;
        if (rst_n && rgb_ch.valid && rgb_ch.ready)
        begin
            got.blue  = rgb_ch.blue_out;
            got.green = rgb_ch.green_out;
            got.red   = rgb_ch.red_out;
            if (expected_rgb.size() == 0)
            begin
                note_failure($sformatf("unexpected result b=%02h g=%02h r=%02h",
                                       got.blue, got.green, got.red));
            end
            else
            begin
                want = expected_rgb.pop_front();
                results_checked++;
                if (got.blue != want.blue || got.green != want.green || got.red != want.red)
                begin
                    note_failure($sformatf(
                        "result %0d: expected b=%02h g=%02h r=%02h, got b=%02h g=%02h r=%02h",
                        results_checked, want.blue, want.green, want.red,
                        got.blue, got.green, got.red));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Every task starts and ends just after a rising edge.
    // ------------------------------------------------------------------

    // Drives one register write; the write enable is left high so that a following
    // write can keep it high without lowering and raising it in the same step.
    task automatic write_reg(input cfg_idx_t idx, input word_t value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            IDX_RED:   red_sel   = value;
            IDX_GREEN: green_sel = value;
            IDX_BLUE:  blue_sel  = value;
            default:   ;
        endcase
    endtask

    task automatic close_writes();
        cfg_we <= 1'b0;
    endtask

    // Writes all three masks and leaves the write enable high for a further write.
    task automatic set_masks(input word_t red_m, input word_t green_m, input word_t blue_m);
        write_reg(IDX_RED, red_m);
        write_reg(IDX_GREEN, green_m);
        write_reg(IDX_BLUE, blue_m);
        settings_count++;
    endtask

    task automatic program_masks(input word_t red_m, input word_t green_m, input word_t blue_m);
        set_masks(red_m, green_m, blue_m);
        close_writes();
    endtask

    // Offers one pixel request and returns once it has been taken. Valid stays high
    // afterwards; a gap before the next request lowers it, and end_burst closes a run.
    task automatic send_pixel(input word_t px);
        int gap;
        gap = 0;
        if (!steady && $urandom_range(0, 99) < 20)
        begin
            gap = $urandom_range(1, 4);
        end
        if (gap > 0)
        begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_ch.valid        <= 1'b1;
        pix_ch.packed_pixel <= px;
        do
        begin
            @(posedge clk);
        end
        while (!pix_ch.ready);
        expected_rgb.push_back(convert_pixel(px));
        pixels_sent++;
    endtask

    task automatic end_burst();
        pix_ch.valid <= 1'b0;
    endtask

    // The masks may only change once every owed result has come back.
    task automatic wait_drained();
        end_burst();
        while (expected_rgb.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // A mix of the mask shapes that matter: empty, full, contiguous runs of any width
    // and position, lone bits and scattered patterns.
    function automatic word_t pick_mask();
        int unsigned w;
        int unsigned s;
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4, 5:
            begin
                w = $urandom_range(1, CHAN_BITS);
                s = $urandom_range(0, CHAN_BITS - w);
                return word_t'(((64'd1 << w) - 64'd1) << s);
            end
            9:       return word_t'(32'd1 << $urandom_range(0, CHAN_BITS - 1));
            default: return word_t'($urandom());
        endcase
    endfunction

    function automatic word_t pick_pixel();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return word_t'($urandom());
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The masks straight out of reset give the ordinary 8-8-8 layout.
    task automatic test_reset_masks();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0080_4020);
        send_pixel(32'h1234_5678);
        send_pixel(32'h00FF_00FF);
        wait_drained();
    endtask

    // Full-width and single-bit masks at both ends of the word, then all masks zero.
    task automatic test_extreme_masks();
        program_masks(32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h8000_0000);
        send_pixel(32'h0000_0001);
        send_pixel(32'h7FFF_FFFE);
        wait_drained();
        program_masks('0, '0, '0);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h0000_0000);
        wait_drained();
    endtask

    // Scattered masks let the field overrun 2^bits - 1, so the scaled value wraps.
    task automatic test_sparse_masks();
        program_masks(32'hAAAA_AAAA, 32'h0000_F00F, 32'h8000_0001);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(32'h5555_5555);
        send_pixel(32'hAAAA_AAAA);
        send_pixel(32'h0000_F00F);
        send_pixel(word_t'($urandom()));
        wait_drained();
    endtask

    // Writes to the spare index must leave all three masks as they were.
    task automatic test_unused_index();
        set_masks(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF);
        write_reg(IDX_UNUSED, '1);
        close_writes();
        send_pixel(32'h00C0_8040);
        send_pixel(32'hFF7F_3F1F);
        wait_drained();
        write_reg(IDX_UNUSED, '0);
        close_writes();
        send_pixel(32'hFFFF_FFFF);
        wait_drained();
    endtask

    // Random masks and pixels over several settings. One setting runs with no idling
    // on either side so that the pipeline is kept completely full.
    task automatic test_random_masks();
        for (int p = 0; p < RANDOM_SETTINGS; p++)
        begin
            set_masks(pick_mask(), pick_mask(), pick_mask());
            if ($urandom_range(0, 2) == 0)
            begin
                write_reg(IDX_UNUSED, word_t'($urandom()));
            end
            close_writes();
            steady = (p == RANDOM_SETTINGS / 2);
            for (int i = 0; i < PIXELS_PER_SETTING; i++)
            begin
                send_pixel(pick_pixel());
            end
            wait_drained();
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_idx             = IDX_RED;
        cfg_data            = '0;
        pix_ch.valid        = 1'b0;
        pix_ch.packed_pixel = '0;
        rgb_ch.ready        = 1'b0;
        steady              = 1'b0;
        fail_count          = 0;
        pixels_sent         = 0;
        results_checked     = 0;
        settings_count      = 1;
        red_sel             = RED_MASK_RST;
        green_sel           = GREEN_MASK_RST;
        blue_sel            = BLUE_MASK_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_masks();
        test_extreme_masks();
        test_sparse_masks();
        test_unused_index();
        test_random_masks();

        // Anything the block produces after this point has no request behind it.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_rgb.size() != 0)
        begin
            note_failure($sformatf("%0d results never arrived", expected_rgb.size()));
        end

        $display("Sent %0d pixel requests and checked %0d results over %0d mask settings,",
                 pixels_sent, results_checked, settings_count);
        $display("covering empty, full, single-bit, contiguous and scattered masks; %0d failures.",
                 fail_count);
        if (fail_count == 0)
        begin
            $display("packed_pixel_mask_to_rgb888 regression: pass");
        end
        else
        begin
            $display("packed_pixel_mask_to_rgb888 regression: fail");
        end
        $finish;
    end

    // A correct run needs well under a tenth of this time.
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d results outstanding.", expected_rgb.size());
        $display("packed_pixel_mask_to_rgb888 regression: fail");
        $finish;
    end

endmodule
